/* design/ccfd_pkg.sv */
// Shared types and constants for the CRC-checked frame deframer.
// Used by the front end, the entry queue, the back end and the checker.
`timescale 1ns / 1ps

package ccfd_pkg;

    // Header window length in bytes.
    localparam int unsigned HDR_LEN = 5;

    // Entries held between the front end and the back end.
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Modbus CRC-16 constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HEAD_BYTE    = 2'd0,
        REG_DATA_TYPE    = 2'd1,
        REG_DATA_COMMAND = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_index;

    // Verdict codes on the final frame byte.
    typedef enum logic [1:0] {
        VERDICT_DATA    = 2'd0,
        VERDICT_OTHER   = 2'd1,
        VERDICT_CRC_ERR = 2'd2,
        VERDICT_NONE    = 2'd3
    } t_verdict;

    // What the back end has to do with a queue entry.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_BODY    = 2'd1,
        KIND_CRC_LOW = 2'd2,
        KIND_CRC_HIGH = 2'd3
    } t_kind;

    // One queue entry. A header entry carries all five window bytes, the
    // other kinds carry a single byte in slot 0.
    typedef struct packed {
        t_kind                     kind;
        logic                      is_data;
        logic [HDR_LEN-1:0][7:0]   bytes;
    } t_entry;

    // Queue status seen by the back end; its full flag gates the input ready.
    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_status;

endpackage

/* design/crc_checked_frame_deframer.sv */
// Top level of the CRC-checked frame deframer.
// Instantiates ccfd_front, ccfd_queue and ccfd_back; types from ccfd_pkg.
`timescale 1ns / 1ps

// The deframer takes one received byte per cycle and forwards the bytes of
// each frame it finds, one byte per output transaction. Hunting bytes are
// consumed without output; when the fifth byte completes a valid header the
// five header bytes are released together and the back end sends them out
// one by one, computing the CRC one byte per cycle while the output does
// not stall. An eight-entry queue between the header hunt and the output
// stage absorbs that burst, so the sustained rate is one byte per cycle;
// the input only stalls when the queue is full, which needs the output side
// to stall. The header burst leaves a backlog of four bytes that only the
// hunt for the next frame works off, so with bytes arriving back to back and
// the output never stalled, the final byte of a frame waits behind that
// backlog; once gaps in the input have drained the queue, it goes straight to
// the output register. The final byte carries tlast and a verdict in tuser.
module crc_checked_frame_deframer import ccfd_pkg::*; #(
    parameter int unsigned MAX_FRAME_LEN = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Frame byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [1:0] verdict
);

    logic       accept;
    logic       push;
    logic       pop;
    t_entry     push_entry;
    t_entry     head;
    t_q_status  q_status;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Header hunt and frame position tracking.
    ccfd_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Entry queue.
    ccfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_status     (q_status)
    );

    // Output serialization and CRC check.
    ccfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_status  (q_status),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_verdict (m_axis_tuser)
    );

endmodule

/* design/ccfd_front.sv */
// Front end of the deframer: configuration registers, header hunt and
// frame position tracking. Depends on ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_front import ccfd_pkg::*; #(
    parameter int unsigned MAX_FRAME_LEN = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel
    input  logic         i_cfg_valid,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    // Received bytes
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    // Entries toward the queue
    output logic         o_push,
    output t_entry       o_entry
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_LEN);
    localparam logic [15:0] MIN_LEN = 16'(HDR_LEN);

    // Frame type codes that may open a frame.
    function automatic logic is_type_code(input logic [7:0] b);
        return (b == 8'h61) || (b == 8'h41) || (b == 8'hC1) ||
               (b == 8'hA1) || (b == 8'h21);
    endfunction

    logic [7:0]       r_head, r_type, r_cmd;
    logic [3:0][7:0]  r_win, n_win;
    logic [2:0]       r_fill, n_fill;
    logic             r_in_frame, n_in_frame;
    logic [16:0]      r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic             r_is_data, n_is_data;

    logic [15:0]      cand_len;
    logic             hdr_ok;
    logic             is_data_now;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 8'hAA;
            r_type <= 8'h61;
            r_cmd  <= 8'hA9;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_HEAD_BYTE:    r_head <= i_cfg_data;
                REG_DATA_TYPE:    r_type <= i_cfg_data;
                REG_DATA_COMMAND: r_cmd  <= i_cfg_data;
                REG_UNUSED:       ;
            endcase
        end
    end

    // Header test on the held head and length bytes plus the incoming type byte.
    assign cand_len = {r_win[1], r_win[2]};
    assign hdr_ok   = (r_win[0] == r_head) && is_type_code(i_byte) &&
                      (cand_len >= MIN_LEN) && (cand_len <= MAX_LEN);

    // The command byte at position 5 can still clear the data frame flag.
    assign is_data_now = r_is_data && !((r_pos == 17'(HDR_LEN)) && (i_byte != r_cmd));

    // Hunt and frame tracking.
    always_comb begin
        n_win      = r_win;
        n_fill     = r_fill;
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_len      = r_len;
        n_is_data  = r_is_data;
        o_push     = 1'b0;
        o_entry    = '0;
        if (i_accept) begin
            if (r_in_frame) begin
                o_push           = 1'b1;
                o_entry.bytes[0] = i_byte;
                o_entry.is_data  = is_data_now;
                n_is_data        = is_data_now;
                n_pos            = r_pos + 17'd1;
                priority if (r_pos < {1'b0, r_len}) begin
                    o_entry.kind = KIND_BODY;
                end else if (r_pos == {1'b0, r_len}) begin
                    o_entry.kind = KIND_CRC_LOW;
                end else begin
                    o_entry.kind = KIND_CRC_HIGH;
                    n_in_frame   = 1'b0;
                    n_fill       = 3'd0;
                    n_pos        = 17'd0;
                    n_is_data    = 1'b0;
                end
            end else if (r_fill < 3'd4) begin
                n_win[r_fill[1:0]] = i_byte;
                n_fill             = r_fill + 3'd1;
            end else if (hdr_ok) begin
                o_push          = 1'b1;
                o_entry.kind    = KIND_HEADER;
                o_entry.is_data = (i_byte == r_type);
                o_entry.bytes   = {i_byte, r_win[3], r_win[2], r_win[1], r_win[0]};
                n_in_frame      = 1'b1;
                n_pos           = 17'(HDR_LEN);
                n_len           = cand_len;
                n_is_data       = (i_byte == r_type);
                n_fill          = 3'd0;
            end else begin
                // Drop the oldest byte and keep hunting.
                n_win  = {i_byte, r_win[3], r_win[2], r_win[1]};
                n_fill = 3'd4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_fill     <= 3'd0;
            r_in_frame <= 1'b0;
            r_pos      <= 17'd0;
            r_len      <= 16'd0;
            r_is_data  <= 1'b0;
        end else begin
            r_win      <= n_win;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_is_data  <= n_is_data;
        end
    end

endmodule

/* design/ccfd_queue.sv */
// Entry queue between the deframer front end and back end.
// Register-based FIFO of ccfd_pkg::t_entry items.
`timescale 1ns / 1ps

module ccfd_queue import ccfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_push_entry,
    input  logic       i_pop,
    output t_entry     o_head,
    output t_q_status  o_status
);

    t_entry               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.head_valid = (r_count != '0);

    // Storage writes need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

/* design/ccfd_back.sv */
// Back end of the deframer: serializes queue entries into output bytes,
// runs the Modbus CRC-16 and forms the verdict. Depends on ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_back import ccfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_q_status   i_status,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last,
    output logic [1:0]  o_verdict
);

    // One byte of the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    logic [2:0]   r_idx;
    logic [15:0]  r_crc;
    logic [7:0]   r_crc_low;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_last;
    t_verdict     r_out_verdict;

    logic         step;
    logic [7:0]   cur_byte;
    logic         hdr_done;
    t_verdict     end_verdict;

    // A byte moves out when the output register is free or being taken.
    assign step     = i_status.head_valid && (!r_out_valid || i_ready);
    assign cur_byte = (i_head.kind == KIND_HEADER) ? i_head.bytes[r_idx] : i_head.bytes[0];
    assign hdr_done = (r_idx == 3'(HDR_LEN - 1));
    assign o_pop    = step && ((i_head.kind != KIND_HEADER) || hdr_done);

    // Received CRC is low byte first.
    assign end_verdict = ({cur_byte, r_crc_low} != r_crc) ? VERDICT_CRC_ERR :
                         (i_head.is_data ? VERDICT_DATA : VERDICT_OTHER);

    // CRC accumulation and header byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 3'd0;
            r_crc     <= CRC_INIT;
            r_crc_low <= 8'd0;
        end else if (step) begin
            unique case (i_head.kind)
                KIND_HEADER: begin
                    r_crc <= crc_byte(r_crc, cur_byte);
                    r_idx <= hdr_done ? 3'd0 : r_idx + 3'd1;
                end
                KIND_BODY:     r_crc     <= crc_byte(r_crc, cur_byte);
                KIND_CRC_LOW:  r_crc_low <= cur_byte;
                KIND_CRC_HIGH: r_crc     <= CRC_INIT;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte    <= cur_byte;
            r_out_last    <= (i_head.kind == KIND_CRC_HIGH);
            r_out_verdict <= (i_head.kind == KIND_CRC_HIGH) ? end_verdict : VERDICT_DATA;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_byte    = r_out_byte;
    assign o_last    = r_out_last;
    assign o_verdict = r_out_verdict;

endmodule

/* design/ccfd_checker.sv */
// Port-level checker for the CRC-checked frame deframer, bound to the top.
// Uses verdict codes from ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_checker import ccfd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // Reset empties the output stage.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Bytes inside a frame carry no verdict.
    a_inner_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == VERDICT_DATA)
        else $error("verdict on a non-final byte");

    // A final byte carries one of the three real verdicts.
    a_end_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser != VERDICT_NONE)
        else $error("undefined verdict code");

    // A stalled transaction holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind crc_checked_frame_deframer ccfd_checker u_ccfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/crc_checked_frame_deframer_tb.sv */
// Self-checking testbench for the CRC-checked frame deframer.
// Depends on ccfd_pkg and crc_checked_frame_deframer from the design folder.
`timescale 1ns / 1ps

module crc_checked_frame_deframer_tb;
    import ccfd_pkg::*;

    localparam int unsigned MAX_FRAME_LEN  = 512;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned SQUEEZE_CYCLES = 60;
    localparam int unsigned PHASE_BUDGET   = 64;
    localparam int unsigned TIMEOUT_NS     = 5_000_000;

    // The five frame type codes that may follow a head byte.
    localparam logic [7:0] TYPE_CODES [5] = '{8'h61, 8'h41, 8'hC1, 8'hA1, 8'h21};

    // One expected output transaction.
    typedef struct {
        logic [7:0] frame_byte;
        logic       frame_end;
        t_verdict   verdict;
    } t_frame_out;

    // How a directed row picks its byte.
    typedef enum logic [1:0] {
        ROW_LITERAL,
        ROW_CRC_LOW,
        ROW_CRC_HIGH,
        ROW_CRC_HIGH_BAD
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] value;
        logic       typed;
        logic       end_flag;
        t_verdict   verdict;
    } t_row;

    // Directed bytes under the reset settings: a minimum-length frame, a
    // length below the guard, a length above the maximum, and a data frame
    // with a corrupted CRC. Final bytes carry their expected verdict.
    localparam t_row DIRECTED [25] = '{
        '{ROW_LITERAL,      8'hAA, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h05, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'hFF, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h41, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_CRC_LOW,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_CRC_HIGH,     8'h00, 1'b1, 1'b1, VERDICT_OTHER},
        '{ROW_LITERAL,      8'hAA, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h04, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h61, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'hAA, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h02, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h01, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h21, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'hAA, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h06, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h5A, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'h61, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_LITERAL,      8'hA9, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_CRC_LOW,      8'h00, 1'b0, 1'b0, VERDICT_DATA},
        '{ROW_CRC_HIGH_BAD, 8'h00, 1'b1, 1'b1, VERDICT_CRC_ERR}
    };

    // Clock, reset and block inputs, all known from time zero.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic [1:0] i_cfg_index   = 2'd0;
    logic [7:0] i_cfg_data    = 8'd0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       m_axis_tready = 1'b0;

    logic       o_cfg_ready;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    // Shadow of the configuration registers.
    logic [7:0] head_cfg = 8'hAA;
    logic [7:0] type_cfg = 8'h61;
    logic [7:0] cmd_cfg  = 8'hA9;

    // Deframer state as the predictor tracks it.
    logic [7:0]  hunt_bytes [HDR_LEN];
    logic [2:0]  hunt_count   = 3'd0;
    logic        framing      = 1'b0;
    logic [16:0] frame_pos    = 17'd0;
    logic [15:0] frame_len    = 16'd0;
    logic [15:0] crc_acc      = CRC_INIT;
    logic [7:0]  crc_low_seen = 8'd0;
    logic        scan_frame   = 1'b0;

    t_frame_out  just_predicted [$];
    t_frame_out  expected_frame_bytes [$];

    int unsigned mismatches    = 0;
    int unsigned phase_results = 0;
    bit          steady        = 1'b0;
    bit          squeeze_req   = 1'b0;
    bit          squeeze_done  = 1'b0;

    crc_checked_frame_deframer #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Modbus CRC-16 over one byte, LSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] crc_over(input logic [7:0] bytes_q [$], input int unsigned n);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int unsigned i = 0; i < n; i++) begin
            acc = crc16_step(acc, bytes_q[i]);
        end
        return acc;
    endfunction

    function automatic bit is_type_code(input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        foreach (TYPE_CODES[k]) begin
            if (TYPE_CODES[k] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Advances the tracked deframer state by one received byte and stages
    // the output transactions that the byte releases.
    task automatic track_rx_byte(input logic [7:0] b);
        logic [15:0] hdr_len;
        logic        hdr_ok;
        t_verdict    v;
        int          i;
        if (framing) begin
            // The command byte is checked at position five, CRC byte or not.
            if (frame_pos == 17'(HDR_LEN) && b != cmd_cfg) begin
                scan_frame = 1'b0;
            end
            if (frame_pos < {1'b0, frame_len}) begin
                crc_acc = crc16_step(crc_acc, b);
                just_predicted.push_back('{b, 1'b0, VERDICT_DATA});
                frame_pos++;
            end else if (frame_pos == {1'b0, frame_len}) begin
                crc_low_seen = b;
                just_predicted.push_back('{b, 1'b0, VERDICT_DATA});
                frame_pos++;
            end else begin
                if ({b, crc_low_seen} != crc_acc) begin
                    v = VERDICT_CRC_ERR;
                end else begin
                    v = scan_frame ? VERDICT_DATA : VERDICT_OTHER;
                end
                just_predicted.push_back('{b, 1'b1, v});
                framing    = 1'b0;
                hunt_count = 3'd0;
                frame_pos  = 17'd0;
                crc_acc    = CRC_INIT;
                scan_frame = 1'b0;
            end
        end else begin
            if (hunt_count >= 3'(HDR_LEN)) begin
                hunt_count = 3'(HDR_LEN - 1);
            end
            hunt_bytes[hunt_count] = b;
            hunt_count++;
            if (hunt_count == 3'(HDR_LEN)) begin
                hdr_len = {hunt_bytes[1], hunt_bytes[2]};
                hdr_ok  = hunt_bytes[0] == head_cfg && is_type_code(hunt_bytes[4]) &&
                          hdr_len >= 16'd5 && hdr_len <= 16'(MAX_FRAME_LEN);
                if (!hdr_ok) begin
                    // Slide the hunt on by one byte.
                    for (i = 0; i < HDR_LEN - 1; i++) begin
                        hunt_bytes[i] = hunt_bytes[i + 1];
                    end
                    hunt_bytes[HDR_LEN - 1] = 8'd0;
                    hunt_count = 3'(HDR_LEN - 1);
                end else begin
                    frame_len = hdr_len;
                    crc_acc   = CRC_INIT;
                    for (i = 0; i < HDR_LEN; i++) begin
                        crc_acc = crc16_step(crc_acc, hunt_bytes[i]);
                        just_predicted.push_back('{hunt_bytes[i], 1'b0, VERDICT_DATA});
                    end
                    scan_frame = hunt_bytes[4] == type_cfg;
                    framing    = 1'b1;
                    frame_pos  = 17'(HDR_LEN);
                    hunt_count = 3'd0;
                end
            end
        end
    endtask

    // Offers one byte, waits for its transaction and records what it causes.
    // A typed row replaces the predicted end flag and verdict of its result.
    task automatic send_rx_byte(input logic [7:0] b, input logic typed = 1'b0,
                                input logic end_flag = 1'b0,
                                input t_verdict verdict = VERDICT_DATA);
        t_frame_out item;
        if (!steady && !(squeeze_req && !squeeze_done) && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_rx_byte(b);
        while (just_predicted.size() != 0) begin
            item = just_predicted.pop_front();
            if (typed && just_predicted.size() == 0) begin
                item.frame_end = end_flag;
                item.verdict   = verdict;
            end
            expected_frame_bytes.push_back(item);
            phase_results++;
        end
    endtask

    // Sends one frame of the given length, random content, optional bad CRC.
    task automatic send_frame(input int unsigned len, input bit bad_crc);
        logic [7:0]  fb [$];
        logic [15:0] c;
        logic [7:0]  typ;
        bit          found;
        typ = ($urandom_range(0, 2) == 0 || !is_type_code(type_cfg)) ?
              TYPE_CODES[$urandom_range(0, 4)] : type_cfg;
        fb.push_back(head_cfg);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        fb.push_back(8'($urandom));
        fb.push_back(typ);
        for (int unsigned i = HDR_LEN; i < len; i++) begin
            if (i == HDR_LEN && $urandom_range(0, 4) < 3) begin
                fb.push_back(cmd_cfg);
            end else begin
                fb.push_back(8'($urandom));
            end
        end
        // In a minimum-length frame the command position is the CRC low byte;
        // often pick byte 3 so that the two coincide.
        if (len == HDR_LEN && $urandom_range(0, 1) == 1) begin
            found = 1'b0;
            for (int t = 0; t < 256 && !found; t++) begin
                fb[3] = 8'(t);
                c = crc_over(fb, len);
                found = c[7:0] == cmd_cfg;
            end
        end
        c = crc_over(fb, len);
        if (bad_crc) begin
            c = c ^ (16'd1 << $urandom_range(0, 15));
        end
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        foreach (fb[i]) begin
            send_rx_byte(fb[i]);
        end
    endtask

    // Loose bytes and headers that must be dropped.
    task automatic send_noise();
        logic [15:0] bad_len;
        logic [7:0]  tcode;
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom));
            end
            1: begin
                bad_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) :
                          16'($urandom_range(MAX_FRAME_LEN + 1, 65535));
                send_rx_byte(head_cfg);
                send_rx_byte(bad_len[15:8]);
                send_rx_byte(bad_len[7:0]);
                send_rx_byte(8'($urandom));
                send_rx_byte(TYPE_CODES[$urandom_range(0, 4)]);
            end
            default: begin
                tcode = 8'($urandom);
                while (is_type_code(tcode)) tcode = 8'($urandom);
                send_rx_byte(head_cfg);
                send_rx_byte(8'h00);
                send_rx_byte(8'($urandom_range(5, 20)));
                send_rx_byte(8'($urandom));
                send_rx_byte(tcode);
            end
        endcase
    endtask

    // Drops the input, waits for every expected transaction and lets the
    // block settle.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (expected_frame_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the three registers, and the spare index when asked.
    task automatic apply_settings(input logic [7:0] head, input logic [7:0] typ,
                                  input logic [7:0] cmd, input bit touch_unused);
        t_reg_index  idx;
        logic [7:0]  val;
        int unsigned n;
        n = touch_unused ? 4 : 3;
        for (int unsigned k = 0; k < n; k++) begin
            idx = t_reg_index'(k);
            case (idx)
                REG_HEAD_BYTE:    val = head;
                REG_DATA_TYPE:    val = typ;
                REG_DATA_COMMAND: val = cmd;
                default:          val = 8'($urandom);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                REG_HEAD_BYTE:    head_cfg = val;
                REG_DATA_TYPE:    type_cfg = val;
                REG_DATA_COMMAND: cmd_cfg  = val;
                default:          ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: mostly frames, some noise, then enough bytes to leave
    // the deframer hunting with an empty window.
    task automatic run_phase(input bit want_squeeze);
        int unsigned sel;
        int unsigned len;
        phase_results = 0;
        if (want_squeeze) begin
            squeeze_req = 1'b1;
            send_frame(64, 1'b0);
        end
        while (phase_results < PHASE_BUDGET) begin
            if ($urandom_range(0, 9) < 7) begin
                sel = $urandom_range(0, 9);
                len = sel < 2 ? $urandom_range(5, 6) :
                      sel < 8 ? $urandom_range(7, 14) : $urandom_range(15, 40);
                send_frame(len, $urandom_range(0, 4) == 0);
            end else begin
                send_noise();
            end
        end
        while (framing || hunt_count != 0) begin
            if (framing) begin
                send_rx_byte(8'($urandom));
            end else begin
                send_frame(7, 1'b0);
            end
        end
        quiesce();
    endtask

    // Main sequence: reset, directed rows, then random phases.
    initial begin
        logic [7:0] b;
        foreach (hunt_bytes[i]) hunt_bytes[i] = 8'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            case (DIRECTED[r].kind)
                ROW_CRC_LOW:      b = crc_acc[7:0];
                ROW_CRC_HIGH:     b = crc_acc[15:8];
                ROW_CRC_HIGH_BAD: b = crc_acc[15:8] ^ 8'h01;
                default:          b = DIRECTED[r].value;
            endcase
            send_rx_byte(b, DIRECTED[r].typed, DIRECTED[r].end_flag, DIRECTED[r].verdict);
        end
        quiesce();

        apply_settings(8'h00, 8'hC1, 8'hFF, 1'b0);
        run_phase(1'b1);
        apply_settings(8'hFF, 8'h21, 8'h00, 1'b0);
        run_phase(1'b0);
        // A type register outside the type codes leaves no data frames.
        apply_settings(8'h5A, 8'h37, 8'h12, 1'b0);
        run_phase(1'b0);
        apply_settings(8'($urandom),
                       $urandom_range(0, 1) ? TYPE_CODES[$urandom_range(0, 4)] : 8'($urandom),
                       8'($urandom), 1'b1);
        run_phase(1'b0);
        apply_settings(8'hAA, 8'h61, 8'hA9, 1'b0);
        steady = 1'b1;
        run_phase(1'b0);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stall bursts, stretches of readiness, and one long
    // hold-off while the sender keeps offering bytes.
    initial begin
        @(posedge i_clk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Compare each output transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_output
        t_frame_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_frame_bytes.size() == 0) begin
                $error("unexpected output transaction: frame_byte %0h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_frame_bytes.pop_front();
                if (m_axis_tdata !== want.frame_byte) begin
                    $error("frame_byte: expected %0h, actual %0h", want.frame_byte, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
design/ccfd_pkg.sv
design/ccfd_front.sv
design/ccfd_queue.sv
design/ccfd_back.sv
design/crc_checked_frame_deframer.sv
design/ccfd_checker.sv
dv/crc_checked_frame_deframer_tb.sv
